// ----- hw/rtl/nwsc_pkg.sv -----
// ----------------------------------------------------------------------------
// nwsc_pkg
// Shared types and constants of the nearest waypoint speed controller.
// ----------------------------------------------------------------------------
package nwsc_pkg;

  // field widths fixed by the interface
  localparam int POS_BITS_DEF = 24;
  localparam int SPEED_W      = 16;
  localparam int GAIN_W       = 16;
  localparam int ACCEL_W      = 16;
  localparam int OP_W         = 2;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_GAIN = '0;

  // item opcodes, code 3 is unused and dropped
  typedef enum logic [OP_W-1:0] {
    OP_POSE  = 2'd0,
    OP_POINT = 2'd1,
    OP_TICK  = 2'd2
  } nwsc_op_t;

  // control and payload of the item in the second stage
  typedef struct packed {
    logic                      vld;
    nwsc_op_t                  op;
    logic                      last;
    logic signed [SPEED_W-1:0] speed;
  } nwsc_s2_t;

endpackage

// ----- hw/rtl/nearest_waypoint_speed_control.sv -----
// ----------------------------------------------------------------------------
// nearest_waypoint_speed_control
// Picks the trajectory point nearest to the vehicle pose and turns its speed
// into a saturated proportional acceleration command on each tick.
//
//   channel  direction  handshake            payload
//   in       sink       in_valid/in_ready    op, pos_x/y/z, speed_in, last_point
//   out      source     out_valid/out_ready  accel_cmd, speed_cmd
//   cfg      slave      APB psel/penable     gain at byte address 0
//
// One item is taken per cycle while nothing stalls; a tick's result passes
// the input register and the squares register before it is loaded into the
// result register. The squaring and the sum and compare stages set the
// clock limit.
// Reset is synchronous, active low, and clears pose, run and target state.
// A waiting result stalls only a tick in the last stage; the input then
// stalls once the input register is full as well.
// ----------------------------------------------------------------------------
module nearest_waypoint_speed_control
  import nwsc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
)
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_op,
  input  logic signed [POS_BITS-1:0] in_pos_x,
  input  logic signed [POS_BITS-1:0] in_pos_y,
  input  logic signed [POS_BITS-1:0] in_pos_z,
  input  logic signed [SPEED_W-1:0]  in_speed_in,
  input  logic                       in_last_point,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [ACCEL_W-1:0]  out_accel_cmd,
  output logic signed [SPEED_W-1:0]  out_speed_cmd,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  logic [GAIN_W-1:0]   gain;
  logic                s2_hold;
  nwsc_s2_t            s2;
  logic [2*POS_BITS:0] sq_x, sq_y, sq_z;

  // configuration registers
  nwsc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .gain        (gain)
  );

  // pose store and squared distances
  nwsc_dist #(.POS_BITS(POS_BITS)) u_dist (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_speed_in   (in_speed_in),
    .in_last_point (in_last_point),
    .s2_hold       (s2_hold),
    .s2            (s2),
    .sq_x          (sq_x),
    .sq_y          (sq_y),
    .sq_z          (sq_z)
  );

  // selection and command
  nwsc_ctrl #(.POS_BITS(POS_BITS)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .s2            (s2),
    .sq_x          (sq_x),
    .sq_y          (sq_y),
    .sq_z          (sq_z),
    .gain          (gain),
    .s2_hold       (s2_hold),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_accel_cmd (out_accel_cmd),
    .out_speed_cmd (out_speed_cmd)
  );

endmodule

// ----- hw/rtl/nwsc_cfg.sv -----
// ----------------------------------------------------------------------------
// nwsc_cfg
// APB-style register file holding the proportional gain.
// ----------------------------------------------------------------------------
module nwsc_cfg
  import nwsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [GAIN_W-1:0]     gain
);

  logic [GAIN_W-1:0]    gain_r;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && (reg_idx == REG_GAIN);

  // gain register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= '0;
    end else if (wr_en) begin
      gain_r <= cfg_pwdata[GAIN_W-1:0];
    end
  end

  // read back
  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == REG_GAIN) begin
      cfg_prdata = {{(CFG_DATA_W-GAIN_W){1'b0}}, gain_r};
    end
  end

  assign gain = gain_r;

endmodule

// ----- hw/rtl/nwsc_dist.sv -----
// ----------------------------------------------------------------------------
// nwsc_dist
// Input register, stored vehicle pose and the three squared axis distances.
// ----------------------------------------------------------------------------
module nwsc_dist
  import nwsc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
)
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OP_W-1:0]            in_op,
  input  logic signed [POS_BITS-1:0] in_pos_x,
  input  logic signed [POS_BITS-1:0] in_pos_y,
  input  logic signed [POS_BITS-1:0] in_pos_z,
  input  logic signed [SPEED_W-1:0]  in_speed_in,
  input  logic                       in_last_point,
  input  logic                       s2_hold,
  output nwsc_s2_t                   s2,
  output logic [2*POS_BITS:0]        sq_x,
  output logic [2*POS_BITS:0]        sq_y,
  output logic [2*POS_BITS:0]        sq_z
);

  localparam int DIFF_W = POS_BITS + 1;
  localparam int SQ_W   = 2 * POS_BITS + 1;

  // stage 1 registers
  logic                       s1_vld_r;
  logic [OP_W-1:0]            s1_op_r;
  logic signed [POS_BITS-1:0] s1_x_r, s1_y_r, s1_z_r;
  logic signed [SPEED_W-1:0]  s1_speed_r;
  logic                       s1_last_r;

  // stored pose
  logic signed [POS_BITS-1:0] veh_x_r, veh_y_r, veh_z_r;
  logic signed [SPEED_W-1:0]  veh_speed_r;

  // stage 2 registers
  nwsc_s2_t    s2_r;
  logic [SQ_W-1:0] sq_x_r, sq_y_r, sq_z_r;

  logic        s1_go;
  logic        in_acc;
  logic        s1_pose;
  logic        s1_tick;
  logic signed [DIFF_W-1:0] dx, dy, dz;
  logic [DIFF_W-1:0] mx, my, mz;
  logic [SQ_W-1:0]   sqx_nxt, sqy_nxt, sqz_nxt;
  nwsc_s2_t          s2_nxt;

  assign s1_go    = s1_vld_r && !s2_hold;
  assign in_ready = !s1_vld_r || !s2_hold;
  assign in_acc   = in_valid && in_ready;
  assign s1_pose  = (nwsc_op_t'(s1_op_r) == OP_POSE);
  assign s1_tick  = (nwsc_op_t'(s1_op_r) == OP_TICK);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= in_op;
      s1_x_r     <= in_pos_x;
      s1_y_r     <= in_pos_y;
      s1_z_r     <= in_pos_z;
      s1_speed_r <= in_speed_in;
      s1_last_r  <= in_last_point;
    end
  end

  // pose update as the item leaves stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      veh_x_r     <= '0;
      veh_y_r     <= '0;
      veh_z_r     <= '0;
      veh_speed_r <= '0;
    end else if (s1_go && s1_pose) begin
      veh_x_r     <= s1_x_r;
      veh_y_r     <= s1_y_r;
      veh_z_r     <= s1_z_r;
      veh_speed_r <= s1_speed_r;
    end
  end

  // axis differences and their magnitudes
  always_comb begin
    dx = DIFF_W'(s1_x_r) - DIFF_W'(veh_x_r);
    dy = DIFF_W'(s1_y_r) - DIFF_W'(veh_y_r);
    dz = DIFF_W'(s1_z_r) - DIFF_W'(veh_z_r);
    mx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    my = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    mz = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
  end

  // three independent squares, registered before the sum
  assign sqx_nxt = SQ_W'(mx * mx);
  assign sqy_nxt = SQ_W'(my * my);
  assign sqz_nxt = SQ_W'(mz * mz);

  // ticks carry the vehicle speed seen at their place in the stream
  always_comb begin
    s2_nxt       = '0;
    s2_nxt.vld   = s1_vld_r;
    s2_nxt.op    = nwsc_op_t'(s1_op_r);
    s2_nxt.last  = s1_last_r;
    s2_nxt.speed = s1_tick ? veh_speed_r : s1_speed_r;
  end

  // stage 2 register, only the valid bit is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.vld <= 1'b0;
    end else if (!s2_hold) begin
      s2_r.vld <= s2_nxt.vld;
    end
    if (s1_go) begin
      s2_r.op    <= s2_nxt.op;
      s2_r.last  <= s2_nxt.last;
      s2_r.speed <= s2_nxt.speed;
      sq_x_r     <= sqx_nxt;
      sq_y_r     <= sqy_nxt;
      sq_z_r     <= sqz_nxt;
    end
  end

  assign s2   = s2_r;
  assign sq_x = sq_x_r;
  assign sq_y = sq_y_r;
  assign sq_z = sq_z_r;

endmodule

// ----- hw/rtl/nwsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// nwsc_ctrl
// Nearest point selection, target speed and the proportional command.
// ----------------------------------------------------------------------------
module nwsc_ctrl
  import nwsc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
)
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  nwsc_s2_t                  s2,
  input  logic [2*POS_BITS:0]       sq_x,
  input  logic [2*POS_BITS:0]       sq_y,
  input  logic [2*POS_BITS:0]       sq_z,
  input  logic [GAIN_W-1:0]         gain,
  output logic                      s2_hold,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ACCEL_W-1:0] out_accel_cmd,
  output logic signed [SPEED_W-1:0] out_speed_cmd
);

  localparam int DIST_W = 2 * POS_BITS + 2;
  localparam int ERR_W  = SPEED_W + 1;
  localparam int PROD_W = GAIN_W + 1 + ERR_W;
  localparam int FRAC   = 8;

  logic [DIST_W-1:0]         best_r;
  logic signed [SPEED_W-1:0] best_speed_r;
  logic                      scan_open_r;
  logic signed [SPEED_W-1:0] target_r;
  logic                      out_valid_r;
  logic signed [ACCEL_W-1:0] accel_r;
  logic signed [SPEED_W-1:0] speed_r;

  logic                      s2_fire;
  logic                      is_point;
  logic                      is_tick;
  logic [DIST_W-1:0]         dist_sum;
  logic                      take;
  logic signed [SPEED_W-1:0] win_speed;
  logic signed [ERR_W-1:0]   err;
  logic signed [PROD_W-1:0]  prod;
  logic                      fits;
  logic signed [ACCEL_W-1:0] accel_nxt;

  assign is_point = (s2.op == OP_POINT);
  assign is_tick  = (s2.op == OP_TICK);
  assign s2_hold  = s2.vld && is_tick && out_valid_r && !out_ready;
  assign s2_fire  = s2.vld && !s2_hold;

  // squared distance and first strict minimum of the run
  assign dist_sum  = DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);
  assign take      = !scan_open_r || (dist_sum < best_r);
  assign win_speed = take ? s2.speed : best_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r       <= '0;
      best_speed_r <= '0;
      scan_open_r  <= 1'b0;
      target_r     <= '0;
    end else if (s2_fire && is_point) begin
      if (take) begin
        best_r       <= dist_sum;
        best_speed_r <= s2.speed;
      end
      scan_open_r <= !s2.last;
      if (s2.last) begin
        target_r <= win_speed;
      end
    end
  end

  // gain times speed error, floored by the shift, then saturated
  always_comb begin
    err       = ERR_W'(target_r) - ERR_W'(s2.speed);
    prod      = PROD_W'($signed({1'b0, gain})) * PROD_W'(err);
    fits      = (prod[PROD_W-1:FRAC+ACCEL_W-1] == '0) || (&prod[PROD_W-1:FRAC+ACCEL_W-1]);
    accel_nxt = prod[FRAC+ACCEL_W-1:FRAC];
    if (!fits) begin
      accel_nxt = prod[PROD_W-1] ? {1'b1, {(ACCEL_W-1){1'b0}}} : {1'b0, {(ACCEL_W-1){1'b1}}};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire && is_tick) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire && is_tick) begin
      accel_r <= accel_nxt;
      speed_r <= target_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_accel_cmd = accel_r;
  assign out_speed_cmd = speed_r;

endmodule

// ----- hw/rtl/nwsc_checker.sv -----
// ----------------------------------------------------------------------------
// nwsc_checker
// Port-level checks on the result channel and the item flow.
// ----------------------------------------------------------------------------
module nwsc_checker
  import nwsc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [OP_W-1:0]           in_op,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [ACCEL_W-1:0] out_accel_cmd,
  input logic signed [SPEED_W-1:0] out_speed_cmd
);

  // a waiting result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accel_cmd) && $stable(out_speed_cmd))
    else $error("result changed while stalled");

  // reset leaves no result pending
  assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // with no result waiting the input side never stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // an accepted tick is followed by a result once it has crossed the pipe
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_TICK) |-> ##[3:$] out_valid)
    else $error("tick produced no result");

endmodule

bind nearest_waypoint_speed_control nwsc_checker u_nwsc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_op         (in_op),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_accel_cmd (out_accel_cmd),
  .out_speed_cmd (out_speed_cmd)
);
